>>> rtl/pgw_pkg.sv
// ----------------------------------------------------------------------------
// pgw_pkg
// Widths, register indexes and fixed-point constants of the gravity-well
// particle update unit.
// ----------------------------------------------------------------------------
`default_nettype none
package pgw_pkg;

  localparam int POS_W   = 20;
  localparam int VEL_W   = 24;
  localparam int SIZE_W  = 13;
  localparam int SHIP_W  = 21;
  localparam int DT_W    = 16;
  localparam int CFG_A_W = 3;
  localparam int CFG_D_W = 21;

  localparam int MAG_W   = 23;  // offset magnitude, Q.8
  localparam int SQ_W    = 46;  // squared magnitude, Q.16
  localparam int DEN_W   = 48;  // 1 + |d|^2, Q.16
  localparam int REM_W   = 64;  // divider remainder
  localparam int Q_W     = 16;  // pull / deflection magnitude, Q.16
  localparam int DIV_STAGES = 8; // two quotient bits a stage
  localparam int ACC_W   = 46;

  localparam logic [CFG_A_W-1:0] REG_FIELD_WIDTH  = 3'd0;
  localparam logic [CFG_A_W-1:0] REG_FIELD_HEIGHT = 3'd1;
  localparam logic [CFG_A_W-1:0] REG_SHIP_X       = 3'd2;
  localparam logic [CFG_A_W-1:0] REG_SHIP_Y       = 3'd3;
  localparam logic [CFG_A_W-1:0] REG_TIME_STEP    = 3'd4;

  localparam logic signed [ACC_W-1:0] FRICTION_Q20 = 46'sd1045955;
  localparam logic signed [ACC_W-1:0] GRAV_Q20     = 46'sd26214;
  localparam logic signed [ACC_W-1:0] SHIPF_Q20    = 46'sd20972;

  localparam logic [DEN_W-1:0] DEN_ONE = 48'd65536;
  localparam logic [POS_W-1:0] POS_MAX = 20'hFFFFF;

  typedef struct packed {
    logic [POS_W-1:0]        px;
    logic [POS_W-1:0]        py;
    logic signed [VEL_W-1:0] vx;
    logic signed [VEL_W-1:0] vy;
  } carry_t;

  typedef struct packed {
    logic [REM_W-1:0] rem;
    logic [DEN_W-1:0] den;
    logic [Q_W-1:0]   q;
    logic             neg;
  } div_lane_t;

endpackage
`default_nettype wire

>>> rtl/particle_gravity_well_update_unit.sv
// ----------------------------------------------------------------------------
// particle_gravity_well_update_unit
// One-frame particle update: well pull, ship deflection, friction, advance
// and wrap, as a fifteen-stage pipeline.
// ----------------------------------------------------------------------------
// Throughput: one word per cycle; busy never rises, the four restoring
//   dividers are pipelined two quotient bits per stage (8 stages).
// The receiver cannot stall, so the pipeline always advances.
// Reset clears the valid bits and loads the register defaults.
`default_nettype none
module particle_gravity_well_update_unit (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                start,
  output logic                               busy,
  input  wire  [pgw_pkg::POS_W-1:0]          in_pos_x,
  input  wire  [pgw_pkg::POS_W-1:0]          in_pos_y,
  input  wire  signed [pgw_pkg::VEL_W-1:0]   in_vel_x,
  input  wire  signed [pgw_pkg::VEL_W-1:0]   in_vel_y,
  output logic                               out_valid,
  output logic [pgw_pkg::POS_W-1:0]          out_new_pos_x,
  output logic [pgw_pkg::POS_W-1:0]          out_new_pos_y,
  output logic signed [pgw_pkg::VEL_W-1:0]   out_new_vel_x,
  output logic signed [pgw_pkg::VEL_W-1:0]   out_new_vel_y,
  input  wire                                cfg_we,
  input  wire  [pgw_pkg::CFG_A_W-1:0]        cfg_addr,
  input  wire  [pgw_pkg::CFG_D_W-1:0]        cfg_wdata
);
  import pgw_pkg::*;

  // configuration
  logic [SIZE_W-1:0]        width_r, height_r;
  logic signed [SHIP_W-1:0] ship_x_r, ship_y_r;
  logic [DT_W-1:0]          dt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= 13'd2560;
      height_r <= 13'd1440;
      ship_x_r <= '0;
      ship_y_r <= '0;
      dt_r     <= 16'd4096;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_FIELD_WIDTH:  width_r  <= cfg_wdata[SIZE_W-1:0];
        REG_FIELD_HEIGHT: height_r <= cfg_wdata[SIZE_W-1:0];
        REG_SHIP_X:       ship_x_r <= $signed(cfg_wdata[SHIP_W-1:0]);
        REG_SHIP_Y:       ship_y_r <= $signed(cfg_wdata[SHIP_W-1:0]);
        REG_TIME_STEP:    dt_r     <= cfg_wdata[DT_W-1:0];
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  // stage 0: offsets, lanes 0/1 = well x/y, 2/3 = ship x/y
  logic              v0_r;
  carry_t            c0_r;
  logic [MAG_W-1:0]  mag0_r [4];
  logic              neg0_r [4];
  logic signed [MAG_W:0] off_nxt [4];

  always_comb begin
    off_nxt[0] = $signed({4'b0, in_pos_x})
               - $signed({4'b0, width_r[SIZE_W-1:1], 8'b0});
    off_nxt[1] = $signed({4'b0, in_pos_y})
               - $signed({4'b0, height_r[SIZE_W-1:1], 8'b0});
    off_nxt[2] = $signed({4'b0, in_pos_x}) - ship_x_r;
    off_nxt[3] = $signed({4'b0, in_pos_y}) - ship_y_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v0_r <= 1'b0;
    else        v0_r <= start;
    c0_r <= '{px: in_pos_x, py: in_pos_y, vx: in_vel_x, vy: in_vel_y};
    for (int i = 0; i < 4; i++) begin
      neg0_r[i] <= off_nxt[i][MAG_W];
      mag0_r[i] <= off_nxt[i][MAG_W] ? MAG_W'(-off_nxt[i]) : off_nxt[i][MAG_W-1:0];
    end
  end

  // stage 1: squares
  logic             v1_r;
  carry_t           c1_r;
  logic [MAG_W-1:0] mag1_r [4];
  logic             neg1_r [4];
  logic [SQ_W-1:0]  sq1_r  [4];

  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else        v1_r <= v0_r;
    c1_r <= c0_r;
    for (int i = 0; i < 4; i++) begin
      mag1_r[i] <= mag0_r[i];
      neg1_r[i] <= neg0_r[i];
      sq1_r[i]  <= SQ_W'(mag0_r[i]) * SQ_W'(mag0_r[i]);
    end
  end

  // stage 2 and divider: sign(d) * floor(|d| * 2^24 / den)
  logic      dv_r [DIV_STAGES+1];
  carry_t    dc_r [DIV_STAGES+1];
  div_lane_t dl_r [DIV_STAGES+1][4];

  always_ff @(posedge clk) begin
    if (!rst_n) dv_r[0] <= 1'b0;
    else        dv_r[0] <= v1_r;
    dc_r[0] <= c1_r;
    for (int i = 0; i < 4; i++) begin
      dl_r[0][i].rem <= {{(REM_W-MAG_W-24){1'b0}}, mag1_r[i], 24'b0};
      dl_r[0][i].den <= (i < 2) ? DEN_ONE + DEN_W'(sq1_r[0]) + DEN_W'(sq1_r[1])
                                : DEN_ONE + DEN_W'(sq1_r[2]) + DEN_W'(sq1_r[3]);
      dl_r[0][i].q   <= '0;
      dl_r[0][i].neg <= neg1_r[i];
    end
  end

  for (genvar j = 0; j < DIV_STAGES; j++) begin : g_div
    localparam int KH = Q_W - 1 - 2*j;
    div_lane_t lane_nxt [4];

    always_comb begin
      for (int i = 0; i < 4; i++) begin
        lane_nxt[i] = dl_r[j][i];
        if (lane_nxt[i].rem >= (REM_W'(lane_nxt[i].den) << KH)) begin
          lane_nxt[i].rem = lane_nxt[i].rem - (REM_W'(lane_nxt[i].den) << KH);
          lane_nxt[i].q[KH] = 1'b1;
        end
        if (lane_nxt[i].rem >= (REM_W'(lane_nxt[i].den) << (KH-1))) begin
          lane_nxt[i].rem = lane_nxt[i].rem - (REM_W'(lane_nxt[i].den) << (KH-1));
          lane_nxt[i].q[KH-1] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) dv_r[j+1] <= 1'b0;
      else        dv_r[j+1] <= dv_r[j];
      dc_r[j+1] <= dc_r[j];
      for (int i = 0; i < 4; i++) dl_r[j+1][i] <= lane_nxt[i];
    end
  end

  // product stage, axis 0 = x, 1 = y
  logic                    vm_r;
  carry_t                  cm_r;
  logic signed [ACC_W-1:0] pf_r [2], pg_r [2], ps_r [2];
  logic signed [ACC_W-1:0] vel_m [2], pull_m [2], defl_m [2];

  always_comb begin
    vel_m[0] = dc_r[DIV_STAGES].vx;
    vel_m[1] = dc_r[DIV_STAGES].vy;
    for (int a = 0; a < 2; a++) begin
      pull_m[a] = $signed({{(ACC_W-Q_W){1'b0}}, dl_r[DIV_STAGES][a].q});
      if (dl_r[DIV_STAGES][a].neg) pull_m[a] = -pull_m[a];
      defl_m[a] = $signed({{(ACC_W-Q_W){1'b0}}, dl_r[DIV_STAGES][a+2].q});
      if (dl_r[DIV_STAGES][a+2].neg) defl_m[a] = -defl_m[a];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vm_r <= 1'b0;
    else        vm_r <= dv_r[DIV_STAGES];
    cm_r <= dc_r[DIV_STAGES];
    for (int a = 0; a < 2; a++) begin
      pf_r[a] <= vel_m[a] * FRICTION_Q20;
      pg_r[a] <= pull_m[a] * GRAV_Q20;
      ps_r[a] <= defl_m[a] * SHIPF_Q20;
    end
  end

  // velocity stage: sum, round half up, saturate
  logic                    va_r;
  carry_t                  ca_r;
  logic signed [VEL_W-1:0] nv_r [2];
  logic signed [ACC_W-1:0] acc_a [2];
  logic signed [ACC_W-21:0] rnd_a [2];

  always_comb begin
    for (int a = 0; a < 2; a++) begin
      acc_a[a] = pf_r[a] - pg_r[a] + ps_r[a] + 46'sd524288;
      rnd_a[a] = acc_a[a][ACC_W-1:20];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) va_r <= 1'b0;
    else        va_r <= vm_r;
    ca_r <= cm_r;
    for (int a = 0; a < 2; a++) begin
      if (rnd_a[a] > 26'sd8388607)       nv_r[a] <= 24'sh7FFFFF;
      else if (rnd_a[a] < -26'sd8388608) nv_r[a] <= 24'sh800000;
      else                               nv_r[a] <= rnd_a[a][VEL_W-1:0];
    end
  end

  // step stage: dt * v in Q.28
  logic                    vp_r;
  logic [POS_W-1:0]        pp_r [2];
  logic signed [VEL_W-1:0] nvp_r [2];
  logic signed [40:0]      st_r [2];

  always_ff @(posedge clk) begin
    if (!rst_n) vp_r <= 1'b0;
    else        vp_r <= va_r;
    pp_r[0] <= ca_r.px;
    pp_r[1] <= ca_r.py;
    for (int a = 0; a < 2; a++) begin
      nvp_r[a] <= nv_r[a];
      st_r[a]  <= 41'(nv_r[a]) * $signed({25'b0, dt_r});
    end
  end

  // position stage: round, advance, wrap, clamp to POS_MAX
  logic signed [40:0]       sr_w [2];
  logic signed [23:0]       np_w [2];
  logic [SIZE_W-1:0]        size_w [2];
  logic signed [23:0]       lim_w [2];
  logic [SIZE_W+7:0]        tgt_w [2];
  logic [SIZE_W+7:0]        res_w [2];
  logic [POS_W-1:0]         pos_nxt [2];

  always_comb begin
    size_w[0] = width_r;
    size_w[1] = height_r;
    for (int a = 0; a < 2; a++) begin
      sr_w[a]  = st_r[a] + 41'sd524288;
      np_w[a]  = $signed({4'b0, pp_r[a]}) + 24'($signed(sr_w[a][40:20]));
      lim_w[a] = $signed({3'b0, size_w[a], 8'b0});
      tgt_w[a] = (size_w[a] == '0) ? '0 : {size_w[a] - 13'd1, 8'b0};
      if (np_w[a] >= lim_w[a])  res_w[a] = '0;
      else if (np_w[a] <= 24'sd0) res_w[a] = tgt_w[a];
      else                      res_w[a] = np_w[a][SIZE_W+7:0];
      pos_nxt[a] = (res_w[a] > (SIZE_W+8)'(POS_MAX)) ? POS_MAX : res_w[a][POS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid <= 1'b0;
    else        out_valid <= vp_r;
    out_new_pos_x <= pos_nxt[0];
    out_new_pos_y <= pos_nxt[1];
    out_new_vel_x <= nvp_r[0];
    out_new_vel_y <= nvp_r[1];
  end

endmodule
`default_nettype wire

>>> tb/sv/tb_particle_gravity_well_update_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_particle_gravity_well_update_unit
// Self-checking bench for the gravity-well particle update unit. A predictor
// computes each updated particle from the input word and a mirror of the
// registers. Output words are compared field by field in order. Register
// settings change between phases, only while the pipeline is empty.
// ----------------------------------------------------------------------------
module tb_particle_gravity_well_update_unit;
  import pgw_pkg::*;

  localparam int PIPE_DRAIN = 24;      // allows margin beyond the pipeline length
  localparam int IDLE_LIMIT = 5000;

  typedef struct {
    logic [POS_W-1:0]        px;
    logic [POS_W-1:0]        py;
    logic signed [VEL_W-1:0] vx;
    logic signed [VEL_W-1:0] vy;
  } particle_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [POS_W-1:0] in_pos_x = '0;
  logic [POS_W-1:0] in_pos_y = '0;
  logic signed [VEL_W-1:0] in_vel_x = '0;
  logic signed [VEL_W-1:0] in_vel_y = '0;
  logic out_valid;
  logic [POS_W-1:0] out_new_pos_x;
  logic [POS_W-1:0] out_new_pos_y;
  logic signed [VEL_W-1:0] out_new_vel_x;
  logic signed [VEL_W-1:0] out_new_vel_y;
  logic cfg_we = 1'b0;
  logic [CFG_A_W-1:0] cfg_addr = '0;
  logic [CFG_D_W-1:0] cfg_wdata = '0;

  particle_gravity_well_update_unit u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_pos_x(in_pos_x), .in_pos_y(in_pos_y),
    .in_vel_x(in_vel_x), .in_vel_y(in_vel_y),
    .out_valid(out_valid),
    .out_new_pos_x(out_new_pos_x), .out_new_pos_y(out_new_pos_y),
    .out_new_vel_x(out_new_vel_x), .out_new_vel_y(out_new_vel_y),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // register mirror
  longint unsigned fld_w, fld_h, dt;
  longint shp_x, shp_y;

  particle_t pending_q[$];
  particle_t expected_q[$];
  int errors = 0;
  int words_in = 0;
  int words_out = 0;
  int idle_cycles = 0;
  bit took = 1'b0;
  int burst_left = 0;
  int gap_left = 0;

  function automatic longint round_q20(longint x);
    return (x + (longint'(1) <<< 19)) >>> 20;
  endfunction

  // sign(num) * floor(|num| * 2^24 / den)
  function automatic longint pull_q16(longint num, longint unsigned den);
    longint unsigned mag;
    longint q;
    mag = (num < 0) ? longint'(-num) : num;
    q = longint'((mag << 24) / den);
    return (num < 0) ? -q : q;
  endfunction

  function automatic longint damped_vel(longint v, longint pull, longint defl);
    longint r;
    r = round_q20(v * 1045955 - pull * 26214 + defl * 20972);
    if (r > 8388607) r = 8388607;
    if (r < -8388608) r = -8388608;
    return r;
  endfunction

  function automatic longint wrapped_pos(longint p, longint v, longint unsigned sz);
    longint np, r;
    np = p + round_q20(v * longint'(dt));
    if (np >= longint'(sz << 8)) r = 0;
    else if (np <= 0) r = (sz == 0) ? 0 : longint'((sz - 1) << 8);
    else r = np;
    if (r > 1048575) r = 1048575;
    return r;
  endfunction

  function automatic particle_t update_particle(particle_t it);
    particle_t res;
    longint px, py, vx, vy, gx, gy, sx, sy, nvx, nvy;
    longint unsigned gden, sden;
    px = it.px;
    py = it.py;
    vx = it.vx;
    vy = it.vy;
    gx = px - longint'((fld_w >> 1) << 8);
    gy = py - longint'((fld_h >> 1) << 8);
    sx = px - shp_x;
    sy = py - shp_y;
    gden = 65536 + gx * gx + gy * gy;
    sden = 65536 + sx * sx + sy * sy;
    nvx = damped_vel(vx, pull_q16(gx, gden), pull_q16(sx, sden));
    nvy = damped_vel(vy, pull_q16(gy, gden), pull_q16(sy, sden));
    res.px = POS_W'(wrapped_pos(px, nvx, fld_w));
    res.py = POS_W'(wrapped_pos(py, nvy, fld_h));
    res.vx = VEL_W'(nvx);
    res.vy = VEL_W'(nvy);
    return res;
  endfunction

  task automatic write_reg(logic [CFG_A_W-1:0] a, logic [CFG_D_W-1:0] d);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= a;
    cfg_wdata <= d;
    case (a)
      REG_FIELD_WIDTH:  fld_w = d[SIZE_W-1:0];
      REG_FIELD_HEIGHT: fld_h = d[SIZE_W-1:0];
      REG_SHIP_X:       shp_x = longint'($signed(d[SHIP_W-1:0]));
      REG_SHIP_Y:       shp_y = longint'($signed(d[SHIP_W-1:0]));
      REG_TIME_STEP:    dt = d[DT_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_regs(int w, int h, int sxv, int syv, int t);
    write_reg(REG_FIELD_WIDTH, CFG_D_W'(w));
    write_reg(REG_FIELD_HEIGHT, CFG_D_W'(h));
    write_reg(REG_SHIP_X, CFG_D_W'(sxv));
    write_reg(REG_SHIP_Y, CFG_D_W'(syv));
    write_reg(REG_TIME_STEP, CFG_D_W'(t));
    // unused indexes: must be ignored
    write_reg(3'd5, CFG_D_W'($urandom));
    write_reg(3'd7, CFG_D_W'($urandom));
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic add(int px, int py, int vx, int vy);
    particle_t it;
    it.px = POS_W'(px);
    it.py = POS_W'(py);
    it.vx = VEL_W'(vx);
    it.vy = VEL_W'(vy);
    pending_q.insert(pending_q.size(), it);
  endtask

  task automatic add_random(int n);
    int lim_x, lim_y;
    lim_x = (fld_w << 8) > 1048575 ? 1048575 : int'(fld_w << 8);
    lim_y = (fld_h << 8) > 1048575 ? 1048575 : int'(fld_h << 8);
    repeat (n) begin
      if ($urandom_range(0, 3) == 0)
        add($urandom, $urandom, $urandom, $urandom);
      else
        add($urandom_range(0, lim_x), $urandom_range(0, lim_y),
            $signed($urandom_range(0, 1 << 20)) - (1 << 19),
            $signed($urandom_range(0, 1 << 20)) - (1 << 19));
    end
  endtask

  task automatic drain;
    wait (pending_q.size() == 0 && expected_q.size() == 0 && !start);
    repeat (PIPE_DRAIN) @(posedge clk);
  endtask

  // driver
  always @(negedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (start && !took) begin
      // word not yet taken: hold
    end else if (gap_left > 0) begin
      start <= 1'b0;
      gap_left--;
    end else if (pending_q.size() > 0) begin
      particle_t it;
      it = pending_q.pop_front();
      in_pos_x <= it.px;
      in_pos_y <= it.py;
      in_vel_x <= it.vx;
      in_vel_y <= it.vy;
      start <= 1'b1;
      if (burst_left > 0) begin
        burst_left--;
      end else begin
        burst_left = $urandom_range(0, 40);
        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
      end
    end else begin
      start <= 1'b0;
    end
  end

  // acceptance and output checking
  always @(posedge clk) begin
    particle_t it, exp_w;
    took = 1'b0;
    if (rst_n) begin
      idle_cycles++;
      if (start && !busy) begin
        it.px = in_pos_x;
        it.py = in_pos_y;
        it.vx = in_vel_x;
        it.vy = in_vel_y;
        expected_q.insert(expected_q.size(), update_particle(it));
        took = 1'b1;
        words_in++;
        idle_cycles = 0;
      end
      if (out_valid) begin
        idle_cycles = 0;
        words_out++;
        if (expected_q.size() == 0) begin
          $error("output word with nothing expected");
          errors++;
        end else begin
          exp_w = expected_q.pop_front();
          if (out_new_pos_x !== exp_w.px) begin
            $error("new_pos_x: expected %0d, got %0d", exp_w.px, out_new_pos_x);
            errors++;
          end
          if (out_new_pos_y !== exp_w.py) begin
            $error("new_pos_y: expected %0d, got %0d", exp_w.py, out_new_pos_y);
            errors++;
          end
          if (out_new_vel_x !== exp_w.vx) begin
            $error("new_vel_x: expected %0d, got %0d", exp_w.vx, out_new_vel_x);
            errors++;
          end
          if (out_new_vel_y !== exp_w.vy) begin
            $error("new_vel_y: expected %0d, got %0d", exp_w.vy, out_new_vel_y);
            errors++;
          end
        end
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin
    fld_w = 2560;
    fld_h = 1440;
    shp_x = 0;
    shp_y = 0;
    dt = 4096;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed, reset values: well centre, ship, extremes, both wrap edges
    add(327680, 184320, 0, 0);
    add(0, 0, 0, 0);
    add(1048575, 1048575, 8388607, 8388607);
    add(0, 0, -8388608, -8388608);
    add(1048575, 0, -8388608, 8388607);
    add(655359, 368639, 1 << 20, 1 << 20);
    add(1, 1, -(1 << 20), -(1 << 20));
    add(256, 256, -256, -256);
    add(327681, 184319, 1, -1);
    add(655360, 368640, 0, 0);
    add(500000, 100000, 8388607, -8388608);
    drain();

    // smallest field, ship at the negative extreme, largest step
    set_regs(1, 1, 21'h100000, 21'h100000, 65535);
    add(0, 0, 0, 0);
    add(255, 255, 8388607, -8388608);
    add(128, 1, 100, -100);
    add_random(100);
    drain();

    // largest legal field, ship at the positive extreme, zero step
    set_regs(4096, 4096, 21'h0FFFFF, 21'h0FFFFF, 0);
    add(1048575, 1048575, 8388607, 8388607);
    add(0, 1048575, -8388608, 0);
    add_random(100);
    drain();

    // zero width, oversize height
    set_regs(0, 8191, $urandom, $urandom, $urandom);
    add(0, 1048575, -8388608, 8388607);
    add(1048575, 0, 8388607, -8388608);
    add_random(100);
    drain();

    repeat (7) begin
      set_regs($urandom_range(0, 8191), $urandom_range(0, 8191), $urandom, $urandom,
               $urandom);
      add_random(100);
      drain();
    end

    $display("%0d particle words in, %0d checked, over 11 register settings",
             words_in, words_out);
    if (errors == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
